@@ design/tcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants, types and fixed-point helpers of the ToT charge calibrator.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int CHANNELS_DEF   = 96;
  localparam int COEF_WIDTH_DEF = 32;
  localparam int NCOEF          = 22;
  localparam int FIT_NCOEF      = 9;

  // coefficient slots within a channel row
  localparam int C_LG_BASE  = 0;
  localparam int C_HG_BASE  = 9;
  localparam int C_HGLG_OFF = 18;
  localparam int C_HGLG_SLP = 19;
  localparam int C_GAIN     = 20;
  localparam int C_PED      = 21;

  // segment limits of the ToT, Q.4
  localparam logic signed [15:0] LG_LO    = 16'sd160;
  localparam logic signed [15:0] LG_HI    = 16'sd464;
  localparam logic signed [15:0] HG_LO    = 16'sd96;
  localparam logic signed [15:0] HG_HI    = 16'sd288;
  localparam logic signed [15:0] T_MAX    = 16'sd1600;
  localparam logic signed [15:0] T_SPLIT  = 16'sd288;
  localparam logic [11:0]        MATCH_LIM = 12'd3000;

  localparam logic signed [31:0] Q_MAX     = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN     = 32'sh80000000;
  localparam logic signed [31:0] Q_MINUS1  = -32'sd65536;

  // divider geometry: 33 quotient bits, 49-bit scaled numerator
  localparam int DIV_QB = 33;
  localparam int DIV_NW = 49;
  localparam int DIV_CW = 66;

  typedef enum logic [1:0] {
    TM_HG,
    TM_LG,
    TM_NONE
  } tmode_t;

  typedef struct packed {
    logic signed [15:0] t;
    logic [11:0]        hga;
    logic [11:0]        lga;
    logic [11:0]        hgm;
    logic [11:0]        lgm;
    logic signed [31:0] c_off;
    logic signed [31:0] c_slp;
    logic signed [31:0] c_gain;
    logic signed [31:0] c_ped;
  } hit_t;

  typedef struct packed {
    logic signed [31:0] hrec;
    logic signed [31:0] lrec;
    logic [11:0]        hgm;
    logic [11:0]        lgm;
    tmode_t             tmode;
    logic signed [31:0] c_gain;
    logic signed [31:0] c_ped;
  } rnd1_t;

  typedef struct packed {
    logic signed [31:0] hrec;
    logic signed [31:0] lrec;
    logic [11:0]        hgm;
    logic [11:0]        lgm;
    tmode_t             tmode;
  } rnd2_t;

  // c * t with t in Q.4, rounded half up
  function automatic logic signed [59:0] mul_t(input logic signed [47:0] c,
                                               input logic signed [15:0] t);
    logic signed [63:0] p;
    p = 64'(c) * 64'(t);
    p = p + 64'sd8;
    return 60'(p >>> 4);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return Q_MAX;
    else if (v < -64'sd2147483648) return Q_MIN;
    else return 32'(v);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sd140737488355327) return 48'sh7FFFFFFFFFFF;
    else if (v < -64'sd140737488355328) return 48'sh800000000000;
    else return 48'(v);
  endfunction

endpackage

@@ design/tcc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/tcc_fit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_fit
// Four-stage evaluation of a three-segment ToT fit: line, quartic, line.
// ----------------------------------------------------------------------------
module tcc_fit (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [15:0]       t,
  input  logic signed [31:0]       c [tcc_pkg::FIT_NCOEF],
  input  logic signed [15:0]       lo_lim,
  input  logic signed [15:0]       hi_lim,
  output logic signed [31:0]       fit_q
);

  logic signed [31:0] l1_a, l2_a, l1_b, l2_b, l1_c, l2_c;
  logic signed [47:0] acc_a, acc_b, acc_c;
  logic signed [15:0] t_a, t_b, t_c;
  logic signed [31:0] c4_a, c3_a, c2_a, c3_b, c2_b, c2_c;
  logic signed [47:0] acc_next;
  logic signed [31:0] fit_next;

  // first step of Horner plus both lines
  always_ff @(posedge clk) begin
    if (en) begin
      l1_a  <= tcc_pkg::sat32(64'(c[0]) + 64'(tcc_pkg::mul_t(48'(c[1]), t)));
      l2_a  <= tcc_pkg::sat32(64'(c[7]) + 64'(tcc_pkg::mul_t(48'(c[8]), t)));
      acc_a <= tcc_pkg::sat48(64'(tcc_pkg::mul_t(48'(c[6]), t)) + 64'(c[5]));
      t_a   <= t;
      c4_a  <= c[4];
      c3_a  <= c[3];
      c2_a  <= c[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_b <= tcc_pkg::sat48(64'(tcc_pkg::mul_t(acc_a, t_a)) + 64'(c4_a));
      l1_b  <= l1_a;
      l2_b  <= l2_a;
      t_b   <= t_a;
      c3_b  <= c3_a;
      c2_b  <= c2_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_c <= tcc_pkg::sat48(64'(tcc_pkg::mul_t(acc_b, t_b)) + 64'(c3_b));
      l1_c  <= l1_b;
      l2_c  <= l2_b;
      t_c   <= t_b;
      c2_c  <= c2_b;
    end
  end

  always_comb begin
    acc_next = tcc_pkg::sat48(64'(tcc_pkg::mul_t(acc_c, t_c)) + 64'(c2_c));
    if (t_c <= 16'sd0) begin
      fit_next = '0;
    end else if (t_c < lo_lim) begin
      fit_next = l1_c;
    end else if (t_c < hi_lim) begin
      fit_next = tcc_pkg::sat32(64'(acc_next));
    end else begin
      fit_next = l2_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fit_q <= fit_next;
    end
  end

endmodule

@@ design/tcc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_div
// Pipelined restoring divider: (num * 2^16) / den, truncated, saturated.
// ----------------------------------------------------------------------------
module tcc_div #(
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [32:0]       num,
  input  logic signed [31:0]       den,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     out_valid,
  output logic signed [31:0]       quo,
  output logic [SIDE_W-1:0]        side_out
);

  localparam int QB = tcc_pkg::DIV_QB;
  localparam int NW = tcc_pkg::DIV_NW;
  localparam int CW = tcc_pkg::DIV_CW;

  logic [NW-1:0]     rem  [0:QB];
  logic [31:0]       dmag [0:QB];
  logic [QB-1:0]     q    [0:QB];
  logic              neg  [0:QB];
  logic              sat  [0:QB];
  logic              vld  [0:QB];
  logic [SIDE_W-1:0] sd   [0:QB];

  logic [32:0]        nmag_in;
  logic [31:0]        dmag_in;
  logic signed [31:0] quo_next;

  assign nmag_in = num[32] ? 33'(-num) : 33'(num);
  assign dmag_in = den[31] ? 32'(-den) : 32'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {nmag_in, 16'd0};
      dmag[0] <= dmag_in;
      q[0]    <= '0;
      neg[0]  <= num[32] ^ den[31];
      sat[0]  <= 1'b0;
      sd[0]   <= side_in;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= QB; k++) begin : g_bit
    localparam int B = QB - k;
    logic [CW-1:0] dsh;
    logic          ge;
    logic          sat_n;

    assign dsh = CW'(dmag[k-1]) << B;
    // keep the quotient bits clear for a zero divisor
    assign ge  = (CW'(rem[k-1]) >= dsh) && (dmag[k-1] != '0);

    if (k == 1) begin : g_first
      assign sat_n = (CW'(rem[k-1]) >= (CW'(dmag[k-1]) << QB)) && (rem[k-1] != '0);
    end else begin : g_rest
      assign sat_n = sat[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? NW'(CW'(rem[k-1]) - dsh) : rem[k-1];
        q[k]    <= q[k-1] | (ge ? (QB'(1) << B) : '0);
        dmag[k] <= dmag[k-1];
        neg[k]  <= neg[k-1];
        sat[k]  <= sat_n;
        sd[k]   <= sd[k-1];
      end
    end
  end

  always_comb begin
    if (sat[QB]) begin
      quo_next = neg[QB] ? tcc_pkg::Q_MIN : tcc_pkg::Q_MAX;
    end else if (!neg[QB]) begin
      quo_next = (q[QB] > 33'h07FFFFFFF) ? tcc_pkg::Q_MAX : $signed(q[QB][31:0]);
    end else begin
      quo_next = (q[QB] > 33'h080000000) ? tcc_pkg::Q_MIN : -$signed(q[QB][31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo      <= quo_next;
      side_out <= sd[QB];
    end
  end

endmodule

@@ design/tot_charge_calibrator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tot_charge_calibrator_unit
// Per-channel ToT fits, amplitude to photoelectron conversion and charge pick.
// ----------------------------------------------------------------------------
// Pipeline: the RAM read at the accepting edge of a hit beat, 4 fit stages,
//   two 35-stage divider rounds and 1 output register lead to m_tvalid.
// Throughput: one beat per cycle; all stages hold while m_tvalid && !m_tready.
// Coefficient beats produce no result. Reset clears valid bits only; the
// coefficient RAMs hold no defined value until written.
module tot_charge_calibrator_unit #(
  parameter int CHANNELS   = tcc_pkg::CHANNELS_DEF,
  parameter int COEF_WIDTH = tcc_pkg::COEF_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // channel, coef_index, coef_value, time_diff, hg_ampl, lg_ampl,
  // hg_ampl_matched, lg_ampl_matched; zero padded
  input  logic [111:0] s_tdata,
  // func
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hg_ampl_rec, lg_ampl_rec, hg_pe, lg_pe, tot_pe, charge_pe
  output logic [191:0] m_tdata
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FIT_LAT = 4;

  logic               en;
  logic               acc_in;
  logic [6:0]         chan;
  logic [4:0]         cidx;
  logic               ch_ok_in;
  logic [COEF_WIDTH-1:0] wdata;
  logic [COEF_WIDTH-1:0] ram_q [tcc_pkg::NCOEF];

  logic               v0;
  logic               ok0;
  logic signed [15:0] t0;
  logic [11:0]        hga0, lga0, hgm0, lgm0;
  logic signed [31:0] coef [tcc_pkg::NCOEF];
  logic signed [31:0] lgc  [tcc_pkg::FIT_NCOEF];
  logic signed [31:0] hgc  [tcc_pkg::FIT_NCOEF];
  logic signed [31:0] lfit, hfit;

  logic                dv [0:FIT_LAT-1];
  tcc_pkg::hit_t       dl [0:FIT_LAT-1];

  logic                tin;
  tcc_pkg::rnd1_t      r1_in, r1_out;
  logic signed [32:0]  num_lg1, num_t1;
  logic signed [31:0]  q_lg1, q_t1;
  logic                r1_valid;

  tcc_pkg::rnd2_t      r2_in, r2_out;
  logic signed [32:0]  num_hpe, num_lg2, num_t2;
  logic signed [31:0]  q_hpe, q_lg2, q_t2;
  logic                r2_valid;

  logic signed [31:0]  hpe, lpe, tpe, chg;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign acc_in   = s_tvalid && en;
  assign chan     = s_tdata[6:0];
  assign cidx     = s_tdata[11:7];
  assign ch_ok_in = int'(chan) < CHANNELS;
  assign wdata    = COEF_WIDTH'($signed(s_tdata[43:12]));

  // one RAM per coefficient slot so a hit reads its whole row at once
  for (genvar k = 0; k < tcc_pkg::NCOEF; k++) begin : g_coef
    logic we;
    assign we = acc_in && !s_tuser && ch_ok_in && (cidx == 5'(k));
    tcc_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (CHANNELS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (AW'(chan)),
      .wdata (wdata),
      .re    (en),
      .raddr (AW'(chan)),
      .rdata (ram_q[k])
    );
    assign coef[k] = ok0 ? 32'($signed(ram_q[k])) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= acc_in && s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok0  <= ch_ok_in;
      t0   <= $signed(s_tdata[59:44]);
      hga0 <= s_tdata[71:60];
      lga0 <= s_tdata[83:72];
      hgm0 <= s_tdata[95:84];
      lgm0 <= s_tdata[107:96];
    end
  end

  always_comb begin
    for (int i = 0; i < tcc_pkg::FIT_NCOEF; i++) begin
      lgc[i] = coef[tcc_pkg::C_LG_BASE + i];
      hgc[i] = coef[tcc_pkg::C_HG_BASE + i];
    end
  end

  tcc_fit u_lg_fit (
    .clk    (clk),
    .en     (en),
    .t      (t0),
    .c      (lgc),
    .lo_lim (tcc_pkg::LG_LO),
    .hi_lim (tcc_pkg::LG_HI),
    .fit_q  (lfit)
  );

  tcc_fit u_hg_fit (
    .clk    (clk),
    .en     (en),
    .t      (t0),
    .c      (hgc),
    .lo_lim (tcc_pkg::HG_LO),
    .hi_lim (tcc_pkg::HG_HI),
    .fit_q  (hfit)
  );

  // carry the hit alongside the fits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FIT_LAT; i++) begin
        dv[i] <= 1'b0;
      end
    end else if (en) begin
      dv[0] <= v0;
      for (int i = 1; i < FIT_LAT; i++) begin
        dv[i] <= dv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= '{t: t0, hga: hga0, lga: lga0, hgm: hgm0, lgm: lgm0,
                 c_off: coef[tcc_pkg::C_HGLG_OFF], c_slp: coef[tcc_pkg::C_HGLG_SLP],
                 c_gain: coef[tcc_pkg::C_GAIN], c_ped: coef[tcc_pkg::C_PED]};
      for (int i = 1; i < FIT_LAT; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  // pick reconstructed amplitudes and the ToT branch
  always_comb begin
    tin = (dl[FIT_LAT-1].t > 16'sd0) && (dl[FIT_LAT-1].t < tcc_pkg::T_MAX);
    r1_in.hrec = (tin && dl[FIT_LAT-1].hgm == '0) ? hfit
               : $signed({4'd0, dl[FIT_LAT-1].hga, 16'd0});
    r1_in.lrec = (tin && dl[FIT_LAT-1].lgm == '0) ? lfit
               : $signed({4'd0, dl[FIT_LAT-1].lga, 16'd0});
    r1_in.hgm    = dl[FIT_LAT-1].hgm;
    r1_in.lgm    = dl[FIT_LAT-1].lgm;
    r1_in.c_gain = dl[FIT_LAT-1].c_gain;
    r1_in.c_ped  = dl[FIT_LAT-1].c_ped;
    if (dl[FIT_LAT-1].t > 16'sd0 && dl[FIT_LAT-1].t < tcc_pkg::T_SPLIT) begin
      r1_in.tmode = tcc_pkg::TM_HG;
    end else if (dl[FIT_LAT-1].t >= tcc_pkg::T_SPLIT) begin
      r1_in.tmode = tcc_pkg::TM_LG;
    end else begin
      r1_in.tmode = tcc_pkg::TM_NONE;
    end
    num_lg1 = $signed({5'd0, dl[FIT_LAT-1].lgm, 16'd0}) - 33'(dl[FIT_LAT-1].c_off);
    num_t1  = 33'(r1_in.lrec) - 33'(dl[FIT_LAT-1].c_off);
  end

  // first round: HG-LG fit of the matched LG amplitude and of the LG rec
  tcc_div #(.SIDE_W($bits(tcc_pkg::rnd1_t))) u_div_lg1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv[FIT_LAT-1]),
    .num       (num_lg1),
    .den       (dl[FIT_LAT-1].c_slp),
    .side_in   (r1_in),
    .out_valid (r1_valid),
    .quo       (q_lg1),
    .side_out  (r1_out)
  );

  tcc_div #(.SIDE_W(1)) u_div_t1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (1'b0),
    .num       (num_t1),
    .den       (dl[FIT_LAT-1].c_slp),
    .side_in   (1'b0),
    .out_valid (),
    .quo       (q_t1),
    .side_out  ()
  );

  always_comb begin
    r2_in.hrec  = r1_out.hrec;
    r2_in.lrec  = r1_out.lrec;
    r2_in.hgm   = r1_out.hgm;
    r2_in.lgm   = r1_out.lgm;
    r2_in.tmode = r1_out.tmode;
    num_hpe = $signed({5'd0, r1_out.hgm, 16'd0}) - 33'(r1_out.c_ped);
    num_lg2 = 33'(q_lg1) - 33'(r1_out.c_ped);
    num_t2  = (r1_out.tmode == tcc_pkg::TM_HG) ? 33'(r1_out.hrec) - 33'(r1_out.c_ped)
                                               : 33'(q_t1) - 33'(r1_out.c_ped);
  end

  // second round: pedestal and gain
  tcc_div #(.SIDE_W($bits(tcc_pkg::rnd2_t))) u_div_hpe (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r1_valid),
    .num       (num_hpe),
    .den       (r1_out.c_gain),
    .side_in   (r2_in),
    .out_valid (r2_valid),
    .quo       (q_hpe),
    .side_out  (r2_out)
  );

  tcc_div #(.SIDE_W(1)) u_div_lg2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (1'b0),
    .num       (num_lg2),
    .den       (r1_out.c_gain),
    .side_in   (1'b0),
    .out_valid (),
    .quo       (q_lg2),
    .side_out  ()
  );

  tcc_div #(.SIDE_W(1)) u_div_t2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (1'b0),
    .num       (num_t2),
    .den       (r1_out.c_gain),
    .side_in   (1'b0),
    .out_valid (),
    .quo       (q_t2),
    .side_out  ()
  );

  // charge by priority: HG, then LG, then ToT
  always_comb begin
    hpe = (r2_out.hgm != '0) ? q_hpe : '0;
    lpe = (r2_out.lgm != '0) ? q_lg2 : '0;
    tpe = (r2_out.tmode == tcc_pkg::TM_NONE) ? tcc_pkg::Q_MINUS1 : q_t2;
    if (hpe > 32'sd0 && r2_out.hgm < tcc_pkg::MATCH_LIM) begin
      chg = hpe;
    end else if (lpe > 32'sd0 && r2_out.lgm < tcc_pkg::MATCH_LIM) begin
      chg = lpe;
    end else begin
      chg = tpe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {chg, tpe, lpe, hpe, r2_out.lrec, r2_out.hrec};
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ToT charge calibrator. It loads the coefficient
// rows of the channels that hits use, then sends a short table of directed
// beats and a few hundred random beats of hits and coefficient writes. Each
// hit result is compared field by field with a given value or with a local
// fixed-point calculation of the fits, photoelectron conversions and charge pick.
// ----------------------------------------------------------------------------
module tb;

  localparam bit FN_COEF = 1'b0;
  localparam bit FN_HIT  = 1'b1;
  localparam int NCH     = tcc_pkg::CHANNELS_DEF;
  localparam int N_LOW   = 12;
  localparam int N_HIGH  = 4;
  localparam int N_RAND  = 720;

  typedef logic signed [31:0] q_t;

  typedef struct {
    bit                 func;
    bit [6:0]           ch;
    bit [4:0]           idx;
    logic signed [31:0] val;
    logic signed [15:0] t;
    bit [11:0]          hga, lga, hgm, lgm;
  } beat_t;

  // same field order as m_tdata, highest first
  typedef struct packed {
    q_t chg, tpe, lpe, hpe, lrec, hrec;
  } charge_t;

  typedef struct {
    beat_t   b;
    bit      typed;
    charge_t res;
  } row_t;

  logic         clk, rst;
  logic         s_tvalid, s_tready, s_tuser;
  logic [111:0] s_tdata;
  logic         m_tvalid, m_tready;
  logic [191:0] m_tdata;

  longint  coef_tab [NCH*tcc_pkg::NCOEF];
  charge_t charge_q [$];
  int      n_err = 0;
  int      src_idle, snk_stall;

  tot_charge_calibrator_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint sat_n(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint scale_t(longint c, longint t);
    return (c * t + 8) >>> 4;
  endfunction

  function automatic longint qdiv(longint num, longint den);
    if (den == 0) return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
    return sat_n((num * 65536) / den, 32);
  endfunction

  function automatic longint coef_of(int ch, int k);
    return ch < NCH ? coef_tab[ch*tcc_pkg::NCOEF + k] : 0;
  endfunction

  function automatic longint tot_fit(int ch, int b, longint t, longint lo, longint hi);
    longint acc;
    if (t <= 0) return 0;
    if (t < lo) return sat_n(coef_of(ch, b) + scale_t(coef_of(ch, b + 1), t), 32);
    if (t < hi) begin
      acc = coef_of(ch, b + 6);
      for (int k = 5; k >= 2; k--) acc = sat_n(scale_t(acc, t) + coef_of(ch, b + k), 48);
      return sat_n(acc, 32);
    end
    return sat_n(coef_of(ch, b + 7) + scale_t(coef_of(ch, b + 8), t), 32);
  endfunction

  function automatic longint hg_pe_of(int ch, longint a);
    return qdiv(a - coef_of(ch, tcc_pkg::C_PED), coef_of(ch, tcc_pkg::C_GAIN));
  endfunction

  function automatic longint lg_pe_of(int ch, longint a);
    return hg_pe_of(ch, qdiv(a - coef_of(ch, tcc_pkg::C_HGLG_OFF),
                             coef_of(ch, tcc_pkg::C_HGLG_SLP)));
  endfunction

  function automatic charge_t calibrate(beat_t b);
    charge_t r;
    longint t, hrec, lrec, hpe, lpe, tpe;
    bit tin;
    t    = b.t;
    tin  = t > 0 && t < 1600;
    hrec = (tin && b.hgm == 0) ? tot_fit(b.ch, tcc_pkg::C_HG_BASE, t, 96, 288)
                               : longint'(b.hga) * 65536;
    lrec = (tin && b.lgm == 0) ? tot_fit(b.ch, tcc_pkg::C_LG_BASE, t, 160, 464)
                               : longint'(b.lga) * 65536;
    hpe  = b.hgm != 0 ? hg_pe_of(b.ch, longint'(b.hgm) * 65536) : 0;
    lpe  = b.lgm != 0 ? lg_pe_of(b.ch, longint'(b.lgm) * 65536) : 0;
    if (t > 0 && t < 288) tpe = hg_pe_of(b.ch, hrec);
    else if (t >= 288)    tpe = lg_pe_of(b.ch, lrec);
    else                  tpe = -65536;
    r.hrec = q_t'(hrec);
    r.lrec = q_t'(lrec);
    r.hpe  = q_t'(hpe);
    r.lpe  = q_t'(lpe);
    r.tpe  = q_t'(tpe);
    if (hpe > 0 && b.hgm < tcc_pkg::MATCH_LIM)      r.chg = q_t'(hpe);
    else if (lpe > 0 && b.lgm < tcc_pkg::MATCH_LIM) r.chg = q_t'(lpe);
    else                                            r.chg = q_t'(tpe);
    return r;
  endfunction

  // mostly plausible calibration words, now and then any 32-bit value
  function automatic logic signed [31:0] pick_coef(int k);
    if ($urandom_range(9) == 0) return $urandom;
    case (k)
      tcc_pkg::C_GAIN:     return $urandom_range(32'h0001_0000, 32'h0028_0000);
      tcc_pkg::C_PED:      return $urandom_range(0, 32'h00C8_0000);
      tcc_pkg::C_HGLG_SLP: return $urandom_range(32'h0000_8000, 32'h0014_0000);
      default:             return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  // channels whose rows are loaded: the lowest and the highest few
  function automatic int filled_ch();
    int c;
    c = $urandom_range(N_LOW + N_HIGH - 1);
    return c < N_LOW ? c : NCH - N_LOW - N_HIGH + c;
  endfunction

  function automatic beat_t coef_beat(int ch, int k, logic signed [31:0] v);
    beat_t b;
    b = '{default: 0};
    b.func = FN_COEF; b.ch = 7'(ch); b.idx = 5'(k); b.val = v;
    b.t = 16'($urandom); b.hga = 12'($urandom);
    return b;
  endfunction

  function automatic beat_t hit_beat(int ch, logic signed [15:0] t,
                                     int hga, int lga, int hgm, int lgm);
    beat_t b;
    b.func = FN_HIT; b.ch = 7'(ch); b.idx = 5'($urandom); b.val = $urandom; b.t = t;
    b.hga = 12'(hga); b.lga = 12'(lga); b.hgm = 12'(hgm); b.lgm = 12'(lgm);
    return b;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    int ch;
    logic signed [15:0] t;
    if ($urandom_range(99) < 15) begin
      b = coef_beat($urandom_range(99) < 90 ? $urandom_range(NCH-1) : $urandom_range(127),
                    $urandom_range(99) < 90 ? $urandom_range(tcc_pkg::NCOEF-1)
                                            : $urandom_range(31), 0);
      b.val = pick_coef(b.idx);
      return b;
    end
    ch = $urandom_range(99) < 92 ? filled_ch() : $urandom_range(NCH, 127);
    case ($urandom_range(3))
      0:       t = 16'($urandom_range(0, 300));
      1:       t = 16'($urandom_range(250, 1700));
      2:       t = 16'($signed($urandom_range(0, 64)) - 32'sd32);
      default: t = 16'($urandom);
    endcase
    return hit_beat(ch, t, $urandom_range(4095), $urandom_range(4095),
                    $urandom_range(1) ? 0 : $urandom_range(1, 4095),
                    $urandom_range(1) ? 0 : $urandom_range(1, 4095));
  endfunction

  // offer one beat, record its effect once it is taken
  task automatic send_beat(beat_t b, bit typed = 0, charge_t res = '0);
    charge_t want;
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= b.func;
    s_tdata  <= {4'd0, b.lgm, b.hgm, b.lga, b.hga, b.t, b.val, b.idx, b.ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (b.func == FN_COEF) begin
      if (b.ch < NCH && b.idx < tcc_pkg::NCOEF)
        coef_tab[b.ch*tcc_pkg::NCOEF + b.idx] = longint'(b.val);
    end else begin
      want = typed ? res : calibrate(b);
      charge_q = {charge_q, want};
    end
  endtask

  always @(posedge clk) begin
    charge_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (charge_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          want = charge_q.pop_front();
          if (got != want) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: hrec %h/%h lrec %h/%h hpe %h/%h lpe %h/%h tpe %h/%h chg %h/%h",
                       want.hrec, got.hrec, want.lrec, got.lrec, want.hpe, got.hpe,
                       want.lpe, got.lpe, want.tpe, got.tpe, want.chg, got.chg);
          end
        end
      end
      m_tready <= $urandom_range(99) >= snk_stall;
    end
  end

  row_t dir_rows [$];

  function automatic void add_row(beat_t b, bit typed, charge_t res);
    row_t r;
    r.b     = b;
    r.typed = typed;
    r.res   = res;
    dir_rows = {dir_rows, r};
  endfunction

  initial begin
    int n;
    rst = 1'b1; s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
    src_idle = 17; snk_stall = 75;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // load every row a hit may read
    for (int c = 0; c < NCH; c++)
      if (c < N_LOW || c >= NCH - N_HIGH)
        for (int k = 0; k < tcc_pkg::NCOEF; k++) send_beat(coef_beat(c, k, pick_coef(k)));

    // out-of-range channels read zero coefficients
    add_row(hit_beat(100, 0, 4095, 0, 0, 0), 1,
            '{tcc_pkg::Q_MINUS1, tcc_pkg::Q_MINUS1, 0, 0, 0, 32'sh0FFF_0000});
    add_row(hit_beat(127, -32768, 0, 4095, 4095, 0), 1,
            '{tcc_pkg::Q_MINUS1, tcc_pkg::Q_MINUS1, 0, tcc_pkg::Q_MAX, 32'sh0FFF_0000, 0});
    // writes that must be dropped: bad index, bad channel
    add_row(coef_beat(7, 22, tcc_pkg::Q_MAX), 0, '0);
    add_row(coef_beat(7, 31, tcc_pkg::Q_MIN), 0, '0);
    add_row(coef_beat(NCH, 0, tcc_pkg::Q_MAX), 0, '0);
    // zero gain, zero slope
    add_row(coef_beat(3, tcc_pkg::C_GAIN, 0), 0, '0);
    add_row(coef_beat(3, tcc_pkg::C_HGLG_SLP, 0), 0, '0);
    add_row(hit_beat(3, 100, 10, 10, 100, 4095), 0, '0);
    add_row(hit_beat(3, 500, 10, 10, 0, 0), 0, '0);
    // extreme coefficients
    add_row(coef_beat(4, tcc_pkg::C_LG_BASE, tcc_pkg::Q_MAX), 0, '0);
    add_row(coef_beat(4, tcc_pkg::C_LG_BASE + 1, tcc_pkg::Q_MIN), 0, '0);
    add_row(coef_beat(4, tcc_pkg::C_HG_BASE + 6, tcc_pkg::Q_MAX), 0, '0);
    add_row(hit_beat(4, 1, 0, 0, 0, 0), 0, '0);
    add_row(hit_beat(4, 32767, 4095, 4095, 2999, 3000), 0, '0);
    // segment edges of both branches and the fit window
    begin
      logic signed [15:0] edges [11] = '{95, 96, 159, 160, 287, 288, 463, 464, 1599, 1600, -1};
      foreach (edges[i]) add_row(hit_beat(i, edges[i], 1234, 2345,
                                          0, i % 3 == 0 ? 2999 : 0), 0, '0);
    end
    foreach (dir_rows[i]) send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);

    for (n = 0; n < N_RAND; n++) begin
      if (n == N_RAND / 3)     begin src_idle = 75; snk_stall = 17; end
      if (n == 2 * N_RAND / 3) begin src_idle = 0;  snk_stall = 0;  end
      send_beat(random_beat());
    end
    s_tvalid <= 1'b0;

    while (charge_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/tcc_pkg.sv
design/tcc_ram.sv
design/tcc_fit.sv
design/tcc_div.sv
design/tot_charge_calibrator_unit.sv
tb/tb.sv
